/* rtl/core/sal20_pkg.sv */
// Shared types, constants and helper functions for the Salsa20/20 stream cipher.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
`timescale 1ns / 1ps

package sal20_pkg;

    localparam int DEFAULT_ROUNDS = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int STEP_W     = 2;

    // "expand 32-byte k" constant words at state positions 0, 5, 10 and 15.
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646E;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2D32;
    localparam logic [31:0] SIGMA_3 = 32'h6B20_6574;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_PART_0  = 3'd0,
        CFG_KEY_PART_1  = 3'd1,
        CFG_KEY_PART_2  = 3'd2,
        CFG_KEY_PART_3  = 3'd3,
        CFG_NONCE_VALUE = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_SERVE,
        ST_ROUND,
        ST_FINAL
    } t_ctrl_state;

    typedef struct packed {
        logic              load;       // copy the initial state into the work registers
        logic              round_en;   // run one ARX step on all four lanes
        logic [STEP_W-1:0] step;       // which of the four steps of a quarter-round
        logic              transpose;  // last step of a round: store the matrix transposed
        logic              finalize;   // add the input state back, bump the counter
        logic              serve_en;   // keystream block may be consumed
    } t_dp_cmd;

    typedef struct packed {
        logic need_block;
    } t_dp_status;

    // Rotation of the n-th step of a quarter-round: 7, 9, 13, 18.
    function automatic logic [31:0] rot_step(input logic [31:0] v,
                                             input logic [STEP_W-1:0] step);
        logic [31:0] r;
        case (step)
            2'd0:    r = {v[24:0], v[31:25]};
            2'd1:    r = {v[22:0], v[31:23]};
            2'd2:    r = {v[18:0], v[31:19]};
            default: r = {v[13:0], v[31:14]};
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/sal20_ctrl.sv */
// Sequencer for block generation: load, ROUNDS x 4 ARX steps, final add.
// Depends on sal20_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps

module sal20_ctrl #(
    parameter int ROUNDS = sal20_pkg::DEFAULT_ROUNDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sal20_pkg::t_dp_status i_status,
    output sal20_pkg::t_dp_cmd    o_cmd
);

    localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    sal20_pkg::t_ctrl_state r_state, n_state;
    logic [sal20_pkg::STEP_W-1:0] r_step, n_step;
    logic [RND_W-1:0]             r_round, n_round;
    logic                         last_step;
    logic                         last_round;
    logic                         start;

    assign last_step  = (r_step == {sal20_pkg::STEP_W{1'b1}});
    assign last_round = (r_round == RND_W'(ROUNDS - 1));
    assign start      = i_in_valid && i_status.need_block;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sal20_pkg::ST_SERVE: begin
                if (start) begin
                    n_state = sal20_pkg::ST_ROUND;
                end
            end
            sal20_pkg::ST_ROUND: begin
                if (last_step && last_round) begin
                    n_state = sal20_pkg::ST_FINAL;
                end
            end
            sal20_pkg::ST_FINAL: begin
                n_state = sal20_pkg::ST_SERVE;
            end
            default: begin
                n_state = sal20_pkg::ST_SERVE;
            end
        endcase
    end

    always_comb begin
        n_step  = r_step;
        n_round = r_round;
        if (r_state == sal20_pkg::ST_ROUND) begin
            n_step = r_step + 1'b1;
            if (last_step) begin
                n_round = r_round + 1'b1;
            end
        end else begin
            n_step  = '0;
            n_round = '0;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.step      = r_step;
        o_cmd.transpose = last_step;
        unique case (r_state)
            sal20_pkg::ST_SERVE: begin
                o_cmd.serve_en = 1'b1;
                o_cmd.load     = start;
            end
            sal20_pkg::ST_ROUND: begin
                o_cmd.round_en = 1'b1;
            end
            sal20_pkg::ST_FINAL: begin
                o_cmd.finalize = 1'b1;
            end
            default: begin
                o_cmd.serve_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sal20_pkg::ST_SERVE;
            r_step  <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_round <= n_round;
        end
    end

endmodule

/* rtl/core/sal20_datapath.sv */
// Key, nonce and counter registers, the 16-word work matrix with four ARX lanes,
// the keystream block and the byte output register. Depends on sal20_pkg.
`timescale 1ns / 1ps

module sal20_datapath #(
    parameter int ROUNDS = sal20_pkg::DEFAULT_ROUNDS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sal20_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sal20_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sal20_pkg::t_in_beat                 i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sal20_pkg::t_out_beat                o_out_beat,
    input  sal20_pkg::t_dp_cmd                  i_cmd,
    output sal20_pkg::t_dp_status               o_status
);

    logic [63:0] r_key [4];
    logic [63:0] r_nonce;
    logic [63:0] r_ctr;
    logic [31:0] r_x   [16];
    logic [31:0] n_x   [16];
    logic [31:0] r_ks  [16];
    logic [5:0]  r_pos;
    logic        r_fresh;
    logic        r_out_valid;
    sal20_pkg::t_out_beat r_out_beat;

    logic [31:0] init_w   [16];
    logic [31:0] x_final  [16];
    logic [31:0] lane_w   [4][4];
    logic [31:0] lane_v   [4][4];
    logic [31:0] lane_sum [4];

    logic        need_block;
    logic        out_free;
    logic        can_take;
    logic        accept;
    logic        cfg_hit;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    // Input state in row-major order.
    always_comb begin
        init_w[0]  = sal20_pkg::SIGMA_0;
        init_w[1]  = r_key[0][31:0];
        init_w[2]  = r_key[0][63:32];
        init_w[3]  = r_key[1][31:0];
        init_w[4]  = r_key[1][63:32];
        init_w[5]  = sal20_pkg::SIGMA_1;
        init_w[6]  = r_nonce[31:0];
        init_w[7]  = r_nonce[63:32];
        init_w[8]  = r_ctr[31:0];
        init_w[9]  = r_ctr[63:32];
        init_w[10] = sal20_pkg::SIGMA_2;
        init_w[11] = r_key[2][31:0];
        init_w[12] = r_key[2][63:32];
        init_w[13] = r_key[3][31:0];
        init_w[14] = r_key[3][63:32];
        init_w[15] = sal20_pkg::SIGMA_3;
    end

    // Lane j works on column j, read starting at the diagonal. Each step writes the
    // column back rotated by one row, so every step has the same operand places.
    // A row round is a column round on the transpose, so the matrix is stored
    // transposed at the end of each round.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 4; k++) begin
                lane_w[j][k] = r_x[4 * ((j + k) & 3) + j];
            end
            lane_sum[j]  = lane_w[j][0] + lane_w[j][3];
            lane_v[j][0] = lane_w[j][1] ^ sal20_pkg::rot_step(lane_sum[j], i_cmd.step);
            lane_v[j][1] = lane_w[j][2];
            lane_v[j][2] = lane_w[j][3];
            lane_v[j][3] = lane_w[j][0];
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_x[i] = r_x[i];
        end
        if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) begin
                n_x[i] = init_w[i];
            end
        end else if (i_cmd.round_en) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 4; k++) begin
                    if (i_cmd.transpose) begin
                        n_x[4 * j + ((j + k) & 3)] = lane_v[j][k];
                    end else begin
                        n_x[4 * ((j + k) & 3) + j] = lane_v[j][k];
                    end
                end
            end
        end
    end

    // After an odd number of rounds the matrix sits transposed.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if ((ROUNDS % 2) == 1) begin
                x_final[i] = r_x[4 * (i & 3) + (i >> 2)];
            end else begin
                x_final[i] = r_x[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) begin
            r_x[i] <= n_x[i];
        end
        if (i_cmd.finalize) begin
            for (int i = 0; i < 16; i++) begin
                r_ks[i] <= x_final[i] + init_w[i];
            end
        end
    end

    assign need_block = (r_pos == 6'd0) && !r_fresh;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign can_take   = i_cmd.serve_en && !need_block && out_free;
    assign accept     = i_in_valid && can_take;
    assign o_in_stall = !can_take;

    assign ks_word = r_ks[r_pos[5:2]];
    assign ks_byte = ks_word[{r_pos[1:0], 3'b000} +: 8];

    always_comb begin
        unique case (i_cfg_index)
            sal20_pkg::CFG_KEY_PART_0,
            sal20_pkg::CFG_KEY_PART_1,
            sal20_pkg::CFG_KEY_PART_2,
            sal20_pkg::CFG_KEY_PART_3,
            sal20_pkg::CFG_NONCE_VALUE: cfg_hit = i_cfg_wr_en;
            default:                    cfg_hit = 1'b0;
        endcase
    end

    // A register write wins over everything else. The final add and an accepted
    // beat never fall in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
            r_nonce <= '0;
            r_ctr   <= '0;
            r_pos   <= '0;
            r_fresh <= 1'b0;
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                sal20_pkg::CFG_KEY_PART_0:  r_key[0] <= i_cfg_wdata;
                sal20_pkg::CFG_KEY_PART_1:  r_key[1] <= i_cfg_wdata;
                sal20_pkg::CFG_KEY_PART_2:  r_key[2] <= i_cfg_wdata;
                sal20_pkg::CFG_KEY_PART_3:  r_key[3] <= i_cfg_wdata;
                default:                    r_nonce  <= i_cfg_wdata;
            endcase
            r_ctr   <= '0;
            r_pos   <= '0;
            r_fresh <= 1'b0;
        end else if (i_cmd.finalize) begin
            r_ctr   <= r_ctr + 64'd1;
            r_fresh <= 1'b1;
        end else if (accept) begin
            r_pos   <= i_in_beat.last_byte ? 6'd0 : r_pos + 6'd1;
            r_fresh <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_beat.data_out <= i_in_beat.data_in ^ ks_byte;
            r_out_beat.last_out <= i_in_beat.last_byte;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_beat          = r_out_beat;
    assign o_status.need_block = need_block;

endmodule

/* rtl/core/salsa20_stream_cipher.sv */
// Salsa20/20 stream cipher, top level: controller plus datapath.
// Depends on sal20_pkg, sal20_ctrl and sal20_datapath.
//
// Usage: load the 256-bit key in four 64-bit writes and the nonce in one write
// through the configuration port (i_cfg_wr_en, i_cfg_index, i_cfg_wdata). Any
// key or nonce write restarts the stream at block 0, byte 0. Then send bytes on
// the input channel (i_in_valid / o_in_stall, i_in_beat); each beat returns one
// beat on the output channel (o_out_valid / i_out_stall, o_out_beat) carrying
// data XOR keystream and a copy of the last-byte flag. A last-byte beat drops
// the rest of the current keystream block.
// Each accepted beat's result is registered and appears in the next cycle. The
// first byte of every 64-byte block waits for block generation: a load,
// 4 * ROUNDS ARX steps (one step of all four quarter-rounds per cycle) and
// the final add. The other 63 bytes go at one per cycle while the output is
// not stalled.
// Reset (synchronous, active low) clears key, nonce, counter and byte position.
// While the output beat is stalled the input is stalled too; nothing is lost.
`timescale 1ns / 1ps

module salsa20_stream_cipher #(
    parameter int ROUNDS = sal20_pkg::DEFAULT_ROUNDS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [sal20_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sal20_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sal20_pkg::t_in_beat              i_in_beat,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output sal20_pkg::t_out_beat             o_out_beat
);

    sal20_pkg::t_dp_cmd    dp_cmd;
    sal20_pkg::t_dp_status dp_status;

    sal20_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    sal20_datapath #(
        .ROUNDS (ROUNDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status)
    );

endmodule

/* rtl/core/sal20_checker.sv */
// Port-level checker for the Salsa20 stream cipher, bound to the top level.
// Depends on sal20_pkg for the beat types.
`timescale 1ns / 1ps

module sal20_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input sal20_pkg::t_in_beat  i_in_beat,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input sal20_pkg::t_out_beat o_out_beat
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // The output register must never be overwritten while its beat is held.
    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while output beat is stalled");

    // Each accepted byte shows up on the next cycle with its last flag.
    a_one_cycle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (o_out_valid && (o_out_beat.last_out == $past(i_in_beat.last_byte))))
        else $error("result beat missing or last flag wrong");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled output beat changed");

endmodule

bind salsa20_stream_cipher sal20_checker u_sal20_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);
